### rtl/core/assert_macros.svh
// Shared assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FBCE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FBCE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/fbce_pkg.sv
package fbce_pkg;

    // Store geometry
    localparam int BANK_BYTES   = 65536;
    localparam int SECTOR_BYTES = 4096;   // power of two, 1024 to 65536
    localparam int BANK_COUNT   = 2;
    localparam int QUEUE_DEPTH  = 4;

    // Unlock addresses and data
    localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
    localparam logic [15:0] ADDR_BANK    = 16'h0000;
    localparam logic [15:0] ADDR_ID_MFR  = 16'h0000;
    localparam logic [15:0] ADDR_ID_DEV  = 16'h0001;
    localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;

    // Command codes
    localparam logic [7:0] CMD_IDENT   = 8'h90;
    localparam logic [7:0] CMD_RESET   = 8'hF0;
    localparam logic [7:0] CMD_ERASE   = 8'h80;
    localparam logic [7:0] CMD_PROGRAM = 8'hA0;
    localparam logic [7:0] CMD_BANK    = 8'hB0;
    localparam logic [7:0] CMD_CHIP    = 8'h10;
    localparam logic [7:0] CMD_SECTOR  = 8'h30;

    // Identity codes
    localparam logic [7:0] ID_MFR_LARGE = 8'hC2;
    localparam logic [7:0] ID_DEV_LARGE = 8'h09;
    localparam logic [7:0] ID_MFR_SMALL = 8'h62;
    localparam logic [7:0] ID_DEV_SMALL = 8'h13;
    localparam logic [7:0] ID_OTHER     = 8'h00;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Work handed from the front part to the back part
    typedef enum logic [2:0] {
        OP_READ,
        OP_IDENT,
        OP_PROGRAM,
        OP_ERASE_SECTOR,
        OP_ERASE_CHIP
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [7:0]  data;   // program byte or identity byte
    } cmd_t;

endpackage

### rtl/core/fbce_queue.sv
`include "assert_macros.svh"

module fbce_queue #(
    parameter int DEPTH = fbce_pkg::QUEUE_DEPTH,
    parameter int IDX_W = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fbce_pkg::cmd_t     push_cmd,
    input  logic [IDX_W-1:0]   push_idx,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output fbce_pkg::cmd_t     head_cmd,
    output logic [IDX_W-1:0]   head_idx
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbce_pkg::cmd_t     cmd_mem [DEPTH];
    logic [IDX_W-1:0]   idx_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = cmd_mem[rd_ptr_reg];
    assign head_idx = idx_mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            idx_mem[wr_ptr_reg] <= push_idx;
        end
    end

    `FBCE_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full)
    `FBCE_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

### rtl/core/fbce_front.sv
module fbce_front #(
    parameter int BANK_COUNT = fbce_pkg::BANK_COUNT,
    parameter int IDX_W      = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    // bus side
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [15:0]        address,
    input  logic [7:0]         write_data,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    // queue side
    input  logic               q_full,
    input  logic               init_busy,
    output logic               push,
    output fbce_pkg::cmd_t     push_cmd,
    output logic [IDX_W-1:0]   push_idx
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_UNLOCK1,
        PH_UNLOCK2,
        PH_IDENT,
        PH_ERASE_ARMED,
        PH_ERASE_UNLOCK1,
        PH_ERASE_UNLOCK2,
        PH_PROGRAM,
        PH_BANK_PICK
    } phase_t;

    localparam logic [15:0] SECTOR_MASK = ~16'(fbce_pkg::SECTOR_BYTES - 1);
    localparam logic        MULTI_BANK  = (BANK_COUNT > 1);

    phase_t       phase_reg, phase_next;
    logic         bank_reg, bank_next;
    logic         large_reg;
    logic         accept;
    logic [15:0]  sector_off;
    logic [7:0]   id_byte;

    assign in_stall   = q_full || init_busy;
    assign accept     = in_valid && !in_stall;
    assign sector_off = address & SECTOR_MASK;

    // Pick the identity byte for the address
    always_comb
    begin
        if (address == fbce_pkg::ADDR_ID_MFR)
        begin
            id_byte = large_reg ? fbce_pkg::ID_MFR_LARGE : fbce_pkg::ID_MFR_SMALL;
        end
        else if (address == fbce_pkg::ADDR_ID_DEV)
        begin
            id_byte = large_reg ? fbce_pkg::ID_DEV_LARGE : fbce_pkg::ID_DEV_SMALL;
        end
        else
        begin
            id_byte = fbce_pkg::ID_OTHER;
        end
    end

    // Classify the item and advance the command sequence
    always_comb
    begin
        phase_next    = phase_reg;
        bank_next     = bank_reg;
        push          = 1'b0;
        push_cmd.code = fbce_pkg::OP_READ;
        push_cmd.data = write_data;
        push_idx      = IDX_W'({bank_reg, address});
        if (accept)
        begin
            if (!kind)
            begin
                push = 1'b1;
                if (phase_reg == PH_IDENT)
                begin
                    push_cmd.code = fbce_pkg::OP_IDENT;
                    push_cmd.data = id_byte;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (address == fbce_pkg::ADDR_UNLOCK1 &&
                            write_data == fbce_pkg::DATA_UNLOCK1)
                        begin
                            phase_next = PH_UNLOCK1;
                        end
                    end
                    PH_UNLOCK1:
                    begin
                        phase_next = (address == fbce_pkg::ADDR_UNLOCK2 &&
                                      write_data == fbce_pkg::DATA_UNLOCK2)
                                     ? PH_UNLOCK2 : PH_IDLE;
                    end
                    PH_UNLOCK2:
                    begin
                        phase_next = PH_IDLE;
                        if (address == fbce_pkg::ADDR_UNLOCK1)
                        begin
                            priority if (write_data == fbce_pkg::CMD_IDENT)
                                phase_next = PH_IDENT;
                            else if (write_data == fbce_pkg::CMD_ERASE)
                                phase_next = PH_ERASE_ARMED;
                            else if (write_data == fbce_pkg::CMD_PROGRAM)
                                phase_next = PH_PROGRAM;
                            else if (write_data == fbce_pkg::CMD_BANK)
                                phase_next = PH_BANK_PICK;
                            else
                                phase_next = PH_IDLE;
                        end
                    end
                    PH_IDENT:
                    begin
                        if (write_data == fbce_pkg::CMD_RESET)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ERASE_ARMED:
                    begin
                        phase_next = (address == fbce_pkg::ADDR_UNLOCK1 &&
                                      write_data == fbce_pkg::DATA_UNLOCK1)
                                     ? PH_ERASE_UNLOCK1 : PH_IDLE;
                    end
                    PH_ERASE_UNLOCK1:
                    begin
                        phase_next = (address == fbce_pkg::ADDR_UNLOCK2 &&
                                      write_data == fbce_pkg::DATA_UNLOCK2)
                                     ? PH_ERASE_UNLOCK2 : PH_IDLE;
                    end
                    PH_ERASE_UNLOCK2:
                    begin
                        phase_next = PH_IDLE;
                        if (address == fbce_pkg::ADDR_UNLOCK1 &&
                            write_data == fbce_pkg::CMD_CHIP)
                        begin
                            push          = 1'b1;
                            push_cmd.code = fbce_pkg::OP_ERASE_CHIP;
                            push_idx      = '0;
                        end
                        else if (write_data == fbce_pkg::CMD_SECTOR)
                        begin
                            push          = 1'b1;
                            push_cmd.code = fbce_pkg::OP_ERASE_SECTOR;
                            push_idx      = IDX_W'({bank_reg, sector_off});
                        end
                    end
                    PH_PROGRAM:
                    begin
                        phase_next    = PH_IDLE;
                        push          = 1'b1;
                        push_cmd.code = fbce_pkg::OP_PROGRAM;
                    end
                    PH_BANK_PICK:
                    begin
                        phase_next = PH_IDLE;
                        if (address == fbce_pkg::ADDR_BANK)
                        begin
                            bank_next = write_data[0] & MULTI_BANK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold sequence state, bank and part select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bank_reg  <= 1'b0;
            large_reg <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            bank_reg  <= bank_next;
            if (cfg_we)
            begin
                large_reg <= cfg_wdata;
            end
        end
    end

endmodule

### rtl/core/fbce_back.sv
`include "assert_macros.svh"

module fbce_back #(
    parameter int BANK_COUNT = fbce_pkg::BANK_COUNT,
    parameter int IDX_W      = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    // queue side
    input  logic               q_empty,
    input  fbce_pkg::cmd_t     head_cmd,
    input  logic [IDX_W-1:0]   head_idx,
    output logic               pop,
    output logic               init_busy,
    // result side
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         read_data
);

    localparam int STORE_BYTES = fbce_pkg::BANK_BYTES * BANK_COUNT;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_PROG_WAIT,
        ST_SWEEP
    } state_t;

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_widx;
    logic [7:0]        mem_wdata;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [7:0]        pdata_reg, pdata_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_free;

    assign init_busy = (state_reg == ST_INIT);
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Carry out the head operation
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pdata_next     = pdata_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_widx       = ptr_reg;
        mem_wdata      = fbce_pkg::ERASED_BYTE;
        unique case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                mem_we    = 1'b1;
                ptr_next  = ptr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (head_cmd.code)
                        fbce_pkg::OP_READ:
                        begin
                            if (out_free)
                            begin
                                pop        = 1'b1;
                                state_next = ST_READ_WAIT;
                            end
                        end
                        fbce_pkg::OP_IDENT:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = head_cmd.data;
                            end
                        end
                        fbce_pkg::OP_PROGRAM:
                        begin
                            pop        = 1'b1;
                            ptr_next   = head_idx;
                            pdata_next = head_cmd.data;
                            state_next = ST_PROG_WAIT;
                        end
                        fbce_pkg::OP_ERASE_SECTOR:
                        begin
                            pop        = 1'b1;
                            ptr_next   = head_idx;
                            left_next  = CNT_W'(fbce_pkg::SECTOR_BYTES);
                            state_next = ST_SWEEP;
                        end
                        fbce_pkg::OP_ERASE_CHIP:
                        begin
                            pop        = 1'b1;
                            ptr_next   = '0;
                            left_next  = CNT_W'(STORE_BYTES);
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = mem_rdata_reg;
                state_next     = ST_IDLE;
            end
            ST_PROG_WAIT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata_reg & pdata_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell store: one write port, one registered read port at the queue head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
        mem_rdata_reg <= mem[head_idx];
    end

    // Hold state, sweep counters and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            left_reg      <= CNT_W'(STORE_BYTES);
            pdata_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            pdata_reg     <= pdata_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    `FBCE_ASSERT_SAME(a_init_queue_empty, clk, rst_n, state_reg == ST_INIT, q_empty)
    `FBCE_ASSERT_SAME(a_read_wait_out_free, clk, rst_n, state_reg == ST_READ_WAIT,
                      !out_valid_reg)
    `FBCE_ASSERT_SAME(a_sweep_count_live, clk, rst_n,
                      state_reg == ST_SWEEP || state_reg == ST_INIT, left_reg != '0)
    `FBCE_ASSERT_NEXT(a_prog_done, clk, rst_n, state_reg == ST_PROG_WAIT,
                      state_reg == ST_IDLE)

endmodule

### rtl/core/flash_backup_command_engine_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  kind, address[15:0], write_data[7:0]
// out      out_valid/ out_stall read_data[7:0]
// cfg      cfg_we               cfg_wdata (part select)
//
// A read returns its byte through the queue, the registered store read and the
// result register; a program reads its cell and then writes it on the store port.
// Items are classified at acceptance, one per cycle while in_stall is low;
// reads and finished commands enter a 4-entry queue. Sector erase sweeps
// SECTOR_BYTES bytes and chip erase BANK_BYTES*BANK_COUNT bytes, one byte
// per cycle on the single write port; in_stall rises when the queue fills
// behind an erase. After reset all BANK_BYTES*BANK_COUNT bytes (131072 by
// default) are swept to 0xFF and in_stall stays high meanwhile.
// out_stall holds the result register; reads queue up behind it.
module flash_backup_command_engine_top #(
    parameter int BANK_COUNT  = fbce_pkg::BANK_COUNT,
    parameter int QUEUE_DEPTH = fbce_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         kind,
    input  logic [15:0]  address,
    input  logic [7:0]   write_data,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   read_data,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    localparam int IDX_W = $clog2(fbce_pkg::BANK_BYTES * BANK_COUNT);

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               init_busy;
    fbce_pkg::cmd_t     push_cmd;
    fbce_pkg::cmd_t     head_cmd;
    logic [IDX_W-1:0]   push_idx;
    logic [IDX_W-1:0]   head_idx;

    fbce_front #(
        .BANK_COUNT (BANK_COUNT),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_idx   (push_idx)
    );

    fbce_queue #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .push_idx (push_idx),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd),
        .head_idx (head_idx)
    );

    fbce_back #(
        .BANK_COUNT (BANK_COUNT),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_cmd  (head_cmd),
        .head_idx  (head_idx),
        .pop       (pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

endmodule

### verif/flash_backup_command_engine_top_tb.sv
`timescale 1ns / 100ps

module flash_backup_command_engine_top_tb;
    import fbce_pkg::*;

    localparam int     STORE_BYTES      = BANK_BYTES * BANK_COUNT;
    localparam int     ITEM_TARGET      = 1450;
    localparam int     SECTOR_ERASE_CAP = 40;
    localparam int     CHIP_ERASE_CAP   = 3;
    localparam int     MAX_REPORTS      = 20;
    localparam longint LIMIT_NS         = 64'd50_000_000;

    // Command sequencer phases of the predictor
    typedef enum logic [3:0] {
        SEQ_READY,
        SEQ_KEY1,
        SEQ_KEY2,
        SEQ_ID,
        SEQ_ERASE_SETUP,
        SEQ_ERASE_KEY1,
        SEQ_ERASE_KEY2,
        SEQ_PROGRAM,
        SEQ_BANK
    } seq_state_t;

    // Directed stimulus rows
    typedef enum logic [1:0] {
        ROW_READ,
        ROW_WRITE,
        ROW_CFG
    } row_op_t;

    typedef struct {
        row_op_t     op;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          has_exp;
        logic [7:0]  exp_byte;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        cfg_we;
    logic        cfg_wdata;

    // Predictor state
    logic [7:0]  cell_mem [STORE_BYTES];
    seq_state_t  seq_state;
    int          bank_sel;
    bit          part_large;

    // Expected read bytes, oldest first
    logic [7:0]  read_expect_q [$];
    logic [7:0]  oldest_byte;

    step_t       script [$];
    logic [15:0] hot_addr [24];

    int          fail_count;
    int          items_sent;
    int          reads_checked;
    int          ident_reads;
    int          sector_erases;
    int          chip_erases;
    int          bank_picks;
    int          cfg_writes;
    int          calm_left;
    bit          last_was_write;

    flash_backup_command_engine_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("flash_backup_command_engine_top_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int cell_at(input logic [15:0] a);
        return (bank_sel * BANK_BYTES + int'(a)) % STORE_BYTES;
    endfunction

    function automatic void fill_erased(input int base, input int len);
        for (int i = base; i < base + len; i++)
            cell_mem[i] = ERASED_BYTE;
    endfunction

    function automatic void flash_reset();
        fill_erased(0, STORE_BYTES);
        seq_state  = SEQ_READY;
        bank_sel   = 0;
        part_large = 1'b1;
    endfunction

    // Clear the aligned sector around the address, clipped at the bank end
    function automatic void erase_sector(input logic [15:0] a);
        int off;
        int len;
        int base;
        off = int'(a) - (int'(a) % SECTOR_BYTES);
        len = SECTOR_BYTES;
        if (off + len > BANK_BYTES)
            len = BANK_BYTES - off;
        base = bank_sel * BANK_BYTES + off;
        if (base + len <= STORE_BYTES)
            fill_erased(base, len);
        sector_erases++;
    endfunction

    // Advance the command sequencer on a write access
    function automatic void apply_write(input logic [15:0] a, input logic [7:0] d);
        case (seq_state)
            SEQ_READY:
                if (a == ADDR_UNLOCK1 && d == DATA_UNLOCK1)
                    seq_state = SEQ_KEY1;
            SEQ_KEY1:
                seq_state = (a == ADDR_UNLOCK2 && d == DATA_UNLOCK2) ? SEQ_KEY2 : SEQ_READY;
            SEQ_KEY2:
            begin
                seq_state = SEQ_READY;
                if (a == ADDR_UNLOCK1)
                begin
                    case (d)
                        CMD_IDENT:   seq_state = SEQ_ID;
                        CMD_ERASE:   seq_state = SEQ_ERASE_SETUP;
                        CMD_PROGRAM: seq_state = SEQ_PROGRAM;
                        CMD_BANK:    seq_state = SEQ_BANK;
                        default:     seq_state = SEQ_READY;
                    endcase
                end
            end
            SEQ_ID:
                if (d == CMD_RESET)
                    seq_state = SEQ_READY;
            SEQ_ERASE_SETUP:
                seq_state = (a == ADDR_UNLOCK1 && d == DATA_UNLOCK1) ? SEQ_ERASE_KEY1 : SEQ_READY;
            SEQ_ERASE_KEY1:
                seq_state = (a == ADDR_UNLOCK2 && d == DATA_UNLOCK2) ? SEQ_ERASE_KEY2 : SEQ_READY;
            SEQ_ERASE_KEY2:
            begin
                if (a == ADDR_UNLOCK1 && d == CMD_CHIP)
                begin
                    fill_erased(0, STORE_BYTES);
                    chip_erases++;
                end
                else if (d == CMD_SECTOR)
                    erase_sector(a);
                seq_state = SEQ_READY;
            end
            SEQ_PROGRAM:
            begin
                cell_mem[cell_at(a)] &= d;
                seq_state = SEQ_READY;
            end
            SEQ_BANK:
            begin
                if (a == ADDR_BANK)
                begin
                    bank_sel = int'(d[0]) & (BANK_COUNT - 1);
                    bank_picks++;
                end
                seq_state = SEQ_READY;
            end
            default:
                seq_state = SEQ_READY;
        endcase
    endfunction

    // Byte returned by a read access; codes follow the part select live
    function automatic logic [7:0] read_byte(input logic [15:0] a);
        if (seq_state == SEQ_ID)
        begin
            ident_reads++;
            if (a == ADDR_ID_MFR)
                return part_large ? ID_MFR_LARGE : ID_MFR_SMALL;
            if (a == ADDR_ID_DEV)
                return part_large ? ID_DEV_LARGE : ID_DEV_SMALL;
            return ID_OTHER;
        end
        return cell_mem[cell_at(a)];
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 9) < 6)
            return hot_addr[$urandom_range(0, 23)];
        return 16'($urandom);
    endfunction

    // Keep a data byte off the erase commands
    function automatic logic [7:0] no_erase(input logic [7:0] d);
        if (d == CMD_SECTOR || d == CMD_CHIP)
            return CMD_PROGRAM;
        return d;
    endfunction

    function automatic void add_row(input row_op_t op, input logic [15:0] a,
                                    input logic [7:0] d, input bit has_exp,
                                    input logic [7:0] exp_byte);
        step_t s;
        s.op       = op;
        s.addr     = a;
        s.data     = d;
        s.has_exp  = has_exp;
        s.exp_byte = exp_byte;
        script.push_back(s);
    endfunction

    // Present one item, hold it until accepted, then predict. Called and
    // returns at a falling edge; valid stays high when the next item follows
    // with no gap.
    task automatic send_item(input bit is_write, input logic [15:0] a, input logic [7:0] d,
                             input bit has_fixed, input logic [7:0] fixed);
        int gap;
        logic [7:0] predicted;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            gap = gap_len();
            if ($urandom_range(0, 39) == 0)
                calm_left = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= is_write;
        address    <= a;
        write_data <= d;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
        last_was_write = is_write;
        if (is_write)
            apply_write(a, d);
        else
        begin
            predicted = read_byte(a);
            read_expect_q.push_back(has_fixed ? fixed : predicted);
        end
        @(negedge clk);
    endtask

    task automatic wr(input logic [15:0] a, input logic [7:0] d);
        send_item(1'b1, a, d, 1'b0, 8'h00);
    endtask

    task automatic rd(input logic [15:0] a);
        send_item(1'b0, a, 8'($urandom), 1'b0, 8'h00);
    endtask

    task automatic unlock_cmd(input logic [7:0] cmd);
        wr(ADDR_UNLOCK1, DATA_UNLOCK1);
        wr(ADDR_UNLOCK2, DATA_UNLOCK2);
        wr(ADDR_UNLOCK1, cmd);
    endtask

    // Stop sending and let the block drain. A trailing read makes sure any
    // erase or program ahead of it has finished.
    task automatic settle_block();
        if (last_was_write)
            rd(pick_addr());
        in_valid <= 1'b0;
        while (read_expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_part(input bit want_large);
        cfg_we    <= 1'b1;
        cfg_wdata <= want_large;
        @(negedge clk);
        cfg_we     <= 1'b0;
        part_large = want_large;
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall pattern and checking
    // ---------------------------------------------------------------

    initial
    begin : result_backpressure
        bit stalled;
        int remaining;
        out_stall = 1'b0;
        stalled   = 1'b0;
        remaining = 0;
        forever
        begin
            @(negedge clk);
            if (remaining == 0)
            begin
                stalled = !stalled;
                if (stalled)
                    remaining = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) :
                                ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) :
                                $urandom_range(1, 3);
                else
                    remaining = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) :
                                $urandom_range(1, 6);
            end
            remaining--;
            out_stall <= stalled;
        end
    end

    // Compare each accepted result with the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (read_expect_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected result, read_data %02h with no read outstanding",
                             $time, read_data);
                fail_count++;
            end
            else
            begin
                oldest_byte = read_expect_q.pop_front();
                reads_checked++;
                if (read_data !== oldest_byte)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, oldest_byte, read_data);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        int pick;
        int n;
        int r;
        int next_cfg_at;
        logic [15:0] a;
        logic [7:0] d;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = 1'b0;
        address        = 16'h0000;
        write_data     = 8'h00;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        fail_count     = 0;
        items_sent     = 0;
        reads_checked  = 0;
        ident_reads    = 0;
        sector_erases  = 0;
        chip_erases    = 0;
        bank_picks     = 0;
        cfg_writes     = 0;
        calm_left      = 0;
        last_was_write = 1'b0;
        flash_reset();

        // Hot addresses: extremes, unlock addresses and a few random ones
        hot_addr[0] = 16'h0000;
        hot_addr[1] = 16'h0001;
        hot_addr[2] = 16'hFFFF;
        hot_addr[3] = ADDR_UNLOCK1;
        hot_addr[4] = ADDR_UNLOCK2;
        for (int i = 5; i < 24; i++)
            hot_addr[i] = 16'($urandom);

        // Reset
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        // erased store and large-part codes right after reset
        add_row(ROW_READ,  16'hFFFF,     8'hFF,        1, ERASED_BYTE);
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_IDENT,    0, 8'h00);
        add_row(ROW_READ,  ADDR_ID_MFR,  8'h00,        1, ID_MFR_LARGE);
        add_row(ROW_READ,  ADDR_ID_DEV,  8'hFF,        1, ID_DEV_LARGE);
        add_row(ROW_READ,  16'hFFFF,     8'h00,        1, ID_OTHER);
        // small part: codes switch while still in identification mode
        add_row(ROW_CFG,   16'h0000,     8'h00,        0, 8'h00);
        add_row(ROW_READ,  ADDR_ID_MFR,  8'h00,        1, ID_MFR_SMALL);
        add_row(ROW_READ,  ADDR_ID_DEV,  8'h00,        1, ID_DEV_SMALL);
        add_row(ROW_WRITE, 16'hFFFF,     CMD_RESET,    0, 8'h00);
        // bank select on the small part, then program the top of bank 1
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_BANK,     0, 8'h00);
        add_row(ROW_WRITE, ADDR_BANK,    8'hFF,        0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_PROGRAM,  0, 8'h00);
        add_row(ROW_WRITE, 16'hFFFF,     8'h00,        0, 8'h00);
        add_row(ROW_READ,  16'hFFFF,     8'h00,        1, 8'h00);
        // broken unlock: second key off its address, then a stray command
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, 16'h2AAB,     DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_PROGRAM,  0, 8'h00);
        add_row(ROW_READ,  ADDR_UNLOCK1, 8'h00,        0, 8'h00);
        // chip erase brings the programmed byte back
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_ERASE,    0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2, 0, 8'h00);
        add_row(ROW_WRITE, ADDR_UNLOCK1, CMD_CHIP,     0, 8'h00);
        add_row(ROW_READ,  16'hFFFF,     8'h00,        1, ERASED_BYTE);
        add_row(ROW_CFG,   16'h0000,     8'h01,        0, 8'h00);

        foreach (script[i])
        begin
            case (script[i].op)
                ROW_CFG:
                begin
                    settle_block();
                    set_part(script[i].data[0]);
                end
                ROW_WRITE:
                    send_item(1'b1, script[i].addr, script[i].data, 1'b0, 8'h00);
                default:
                    send_item(1'b0, script[i].addr, script[i].data,
                              script[i].has_exp, script[i].exp_byte);
            endcase
        end

        // Random command sequences with random content, plus noise
        next_cfg_at = items_sent + $urandom_range(100, 200);
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_cfg_at)
            begin
                settle_block();
                set_part(($urandom_range(0, 3) == 0) ? part_large : !part_large);
                next_cfg_at = items_sent + $urandom_range(100, 200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // read burst
                n = $urandom_range(1, 4);
                repeat (n) rd(pick_addr());
            end
            else if (pick < 50)
            begin
                // byte program, often read back
                unlock_cmd(CMD_PROGRAM);
                a = pick_addr();
                d = ($urandom_range(0, 2) == 0) ? 8'($urandom) | 8'($urandom) : 8'($urandom);
                wr(a, d);
                if ($urandom_range(0, 1) == 0)
                    rd(a);
            end
            else if (pick < 60)
            begin
                // identification mode with stray writes, usually left again
                unlock_cmd(CMD_IDENT);
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 3)
                        rd(ADDR_ID_MFR);
                    else if (r < 6)
                        rd(ADDR_ID_DEV);
                    else if (r < 8)
                        rd(pick_addr());
                    else
                    begin
                        d = 8'($urandom);
                        wr(pick_addr(), (d == CMD_RESET) ? CMD_IDENT : d);
                    end
                end
                if ($urandom_range(0, 99) < 85)
                    wr(16'($urandom), CMD_RESET);
            end
            else if (pick < 68)
            begin
                // bank select, now and then off address zero
                unlock_cmd(CMD_BANK);
                wr(($urandom_range(0, 5) == 0) ? pick_addr() : ADDR_BANK, 8'($urandom));
            end
            else if (pick < 76)
            begin
                // erase; budget the slow ones
                unlock_cmd(CMD_ERASE);
                wr(ADDR_UNLOCK1, DATA_UNLOCK1);
                wr(ADDR_UNLOCK2, DATA_UNLOCK2);
                r = $urandom_range(0, 99);
                if (chip_erases < CHIP_ERASE_CAP && r < 4)
                    wr(ADDR_UNLOCK1, CMD_CHIP);
                else if (sector_erases < SECTOR_ERASE_CAP && r < 80)
                    wr(pick_addr(), CMD_SECTOR);
                else
                    wr(pick_addr(), no_erase(8'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    rd(pick_addr());
            end
            else if (pick < 88)
            begin
                // broken sequences
                r = $urandom_range(0, 3);
                if (r == 0)
                begin
                    wr(ADDR_UNLOCK1, DATA_UNLOCK1);
                    wr(pick_addr(), 8'($urandom));
                end
                else if (r == 1)
                begin
                    wr(ADDR_UNLOCK1, DATA_UNLOCK1);
                    wr(ADDR_UNLOCK2, DATA_UNLOCK2);
                    a = 16'($urandom);
                    wr((a == ADDR_UNLOCK1) ? ADDR_UNLOCK2 : a,
                       ($urandom_range(0, 1) == 0) ? CMD_PROGRAM : CMD_IDENT);
                end
                else if (r == 2)
                begin
                    wr(ADDR_UNLOCK1, DATA_UNLOCK1);
                    wr(ADDR_UNLOCK2, DATA_UNLOCK2);
                    wr(ADDR_UNLOCK1, no_erase(8'($urandom)));
                end
                else
                begin
                    wr(ADDR_UNLOCK1 ^ 16'(1 << $urandom_range(0, 15)), DATA_UNLOCK1);
                    wr(ADDR_UNLOCK2, DATA_UNLOCK2);
                    wr(ADDR_UNLOCK1, CMD_PROGRAM);
                end
                rd(pick_addr());
            end
            else
            begin
                // noise
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 0)
                        wr(16'($urandom), no_erase(8'($urandom)));
                    else
                        rd(16'($urandom));
                end
            end
        end

        // Drain and wrap up
        settle_block();
        repeat (16) @(negedge clk);
        $display("Run covered %0d items: %0d reads checked, %0d of them in identification mode,",
                 items_sent, reads_checked, ident_reads);
        $display("%0d sector and %0d chip erases, %0d bank selects, %0d part-select writes.",
                 sector_erases, chip_erases, bank_picks, cfg_writes);
        if (fail_count == 0)
            $display("flash_backup_command_engine_top_tb passed");
        else
            $display("flash_backup_command_engine_top_tb failed");
        $finish;
    end

endmodule
